/* hw/rtl/bit_aligned_glyph_row_blit_defines.svh */
// ----------------------------------------------------------------------------
// Glyph row blit assertion macros
// Shared concurrent check forms, clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BIT_ALIGNED_GLYPH_ROW_BLIT_DEFINES_SVH
`define BIT_ALIGNED_GLYPH_ROW_BLIT_DEFINES_SVH

// condition holds at every enabled edge
`define GBLIT_CHK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond) \
        else $error(msg);

// trigger implies condition at the same edge
`define GBLIT_CHK_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) trig |-> cond) \
        else $error(msg);

// trigger implies condition at the next edge
`define GBLIT_CHK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) trig |=> cond) \
        else $error(msg);

`endif

/* hw/rtl/gblit_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph row blit package
// Field widths, bus widths and reset values shared by the blit modules.
// ----------------------------------------------------------------------------
package gblit_pkg;

    localparam int SRC_W      = 32;
    localparam int OFF_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 6;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] GW_RESET = 6'd8;

endpackage

/* hw/rtl/gblit_front.sv */
// ----------------------------------------------------------------------------
// Glyph row blit front end
// Holds the width register, accepts a row, shifts it into byte position and
// merges the edge bytes with their old contents into one queue entry.
// ----------------------------------------------------------------------------
module gblit_front #(
    parameter int LIM        = 32,
    parameter int SPAN_BYTES = 5,
    parameter int IW         = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gblit_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic [gblit_pkg::IN_DATA_W-1:0]     i_tdata,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [SPAN_BYTES*8+IW-1:0]          o_entry
);

    localparam int SpanBits = SPAN_BYTES * 8;
    localparam int SrcW     = gblit_pkg::SRC_W;
    localparam int CfgW     = gblit_pkg::CFG_W;

    logic [CfgW-1:0]     r_glyph_width;
    logic [CfgW-1:0]     w_width;
    logic [SrcW-1:0]     w_src;
    logic [2:0]          w_off;
    logic [7:0]          w_old_first;
    logic [7:0]          w_old_last;
    logic [SrcW-1:0]     w_wmask;
    logic [63:0]         w_data64;
    logic [63:0]         w_span64;
    logic [SpanBits-1:0] w_data;
    logic [SpanBits-1:0] w_span;
    logic [6:0]          w_sum;
    logic [3:0]          w_last_full;
    logic [IW-1:0]       w_last_idx;
    logic [SpanBits-1:0] w_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width <= gblit_pkg::GW_RESET;
        end else if (i_cfg_we) begin
            r_glyph_width <= i_cfg_wdata;
        end
    end

    assign w_src       = i_tdata[31:0];
    assign w_off       = i_tdata[34:32];
    assign w_old_first = i_tdata[42:35];
    assign w_old_last  = i_tdata[50:43];

    always_comb begin
        priority if (r_glyph_width == '0) begin
            w_width = CfgW'(1);
        end else if (r_glyph_width > CfgW'(LIM)) begin
            w_width = CfgW'(LIM);
        end else begin
            w_width = r_glyph_width;
        end
    end

    assign w_wmask     = ~({SrcW{1'b1}} >> w_width);
    assign w_data64    = {w_src & w_wmask, 32'b0} >> w_off;
    assign w_span64    = {w_wmask, 32'b0} >> w_off;
    assign w_data      = w_data64[63 -: SpanBits];
    assign w_span      = w_span64[63 -: SpanBits];
    assign w_sum       = 7'(w_off) + 7'(w_width) + 7'd7;
    assign w_last_full = w_sum[6:3] - 4'd1;
    assign w_last_idx  = w_last_full[IW-1:0];

    always_comb begin
        logic [7:0] d;
        logic [7:0] m;
        logic [7:0] old;
        for (int k = 0; k < SPAN_BYTES; k++) begin
            d = w_data[SpanBits-1-8*k -: 8];
            m = w_span[SpanBits-1-8*k -: 8];
            if (k == 0) begin
                old = w_old_first;
            end else if (IW'(k) == w_last_idx) begin
                old = w_old_last;
            end else begin
                old = 8'h00;
            end
            w_bytes[8*k +: 8] = (old & ~m) | (d & m);
        end
    end

    assign o_valid  = i_tvalid;
    assign o_tready = i_ready;
    assign o_entry  = {w_last_idx, w_bytes};

endmodule

/* hw/rtl/gblit_queue.sv */
// ----------------------------------------------------------------------------
// Glyph row blit queue
// Two-entry queue of prepared rows between the front end and the byte sender.
// ----------------------------------------------------------------------------
module gblit_queue #(
    parameter int WIDTH = 43
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    logic [WIDTH-1:0] r_mem [Depth];
    logic [PtrW-1:0]  r_wptr;
    logic [PtrW-1:0]  r_rptr;
    logic [CntW-1:0]  r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + CntW'(w_push) - CntW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/gblit_back.sv */
// ----------------------------------------------------------------------------
// Glyph row blit byte sender
// Walks the head row of the queue into a registered output stage, one
// destination byte per cycle while i_tready does not stall the output.
// ----------------------------------------------------------------------------
`include "bit_aligned_glyph_row_blit_defines.svh"

module gblit_back #(
    parameter int SPAN_BYTES = 5,
    parameter int IW         = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [SPAN_BYTES*8+IW-1:0]           i_q_data,
    output logic                                 o_q_pop,
    output logic                                 o_tvalid,
    input  logic                                 i_tready,
    output logic [gblit_pkg::OUT_DATA_W-1:0]     o_tdata,
    output logic                                 o_tlast
);

    localparam int SpanBits = SPAN_BYTES * 8;
    localparam int EntryW   = SpanBits + IW;
    localparam int IdxW     = gblit_pkg::IDX_W;
    localparam int PadW     = gblit_pkg::OUT_DATA_W - IdxW - gblit_pkg::BYTE_W;

    logic [SpanBits-1:0] w_q_bytes;
    logic [IW-1:0]       w_q_last;
    logic                w_load;
    logic                w_is_last;
    logic [IW-1:0]       r_idx;
    logic                r_out_valid;
    logic [IW-1:0]       r_out_idx;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    assign w_q_bytes = i_q_data[SpanBits-1:0];
    assign w_q_last  = i_q_data[EntryW-1 -: IW];
    assign w_load    = i_q_valid && (!r_out_valid || i_tready);
    assign w_is_last = (r_idx == w_q_last);
    assign o_q_pop   = w_load && w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
            r_idx       <= w_is_last ? '0 : r_idx + 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx  <= r_idx;
            r_out_byte <= w_q_bytes[{r_idx, 3'b000} +: 8];
            r_out_last <= w_is_last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {{PadW{1'b0}}, r_out_byte, IdxW'(r_out_idx)};
    assign o_tlast  = r_out_last;

    `GBLIT_CHK_IMPL(a_idx_in_row, i_q_valid, r_idx <= w_q_last, "byte index past row end")
    `GBLIT_CHK_IMPL(a_idx_idle_zero, !i_q_valid, r_idx == '0, "byte index not reset")
    `GBLIT_CHK_NEXT(a_row_contiguous, o_tvalid && i_tready && !o_tlast,
                    o_tvalid && (r_out_idx == $past(r_out_idx) + 1'b1), "row bytes not contiguous")
    `GBLIT_CHK(a_pop_only_valid, !o_q_pop || i_q_valid, "pop from empty queue")

endmodule

/* hw/rtl/bit_aligned_glyph_row_blit.sv */
// Flow: an accepted row enters the queue; its first byte is then registered out.
// Throughput: one destination byte per cycle unless m_axis_tready stalls it; a
// row spans ceil((pixel_offset + width) / 8) destination bytes, 1 to 5.
// A two-row queue lets the next row be accepted while bytes are still going out.
// Reset: glyph_width returns to 8, queue and output stage empty.
// ----------------------------------------------------------------------------
// Bit-aligned glyph row blit
// Shifts a 1-bpp MSB-first glyph row into destination bytes, keeping the
// bits outside the span in the first and last bytes.
// ----------------------------------------------------------------------------
module bit_aligned_glyph_row_blit #(
    parameter int MAX_GLYPH_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gblit_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // source_bits[31:0], pixel_offset[34:32], old_first_byte[42:35],
    // old_last_byte[50:43], zero fill [55:51]
    input  logic [gblit_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // byte_index[2:0], byte_value[10:3], zero fill [15:11]
    output logic [gblit_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int Lim       = (MAX_GLYPH_WIDTH < gblit_pkg::SRC_W) ?
                               MAX_GLYPH_WIDTH : gblit_pkg::SRC_W;
    localparam int SpanBytes = (Lim + 7 + 7) / 8;
    localparam int Iw        = $clog2(SpanBytes);
    localparam int EntryW    = SpanBytes * 8 + Iw;

    logic              w_f_valid;
    logic              w_f_ready;
    logic [EntryW-1:0] w_f_entry;
    logic              w_q_valid;
    logic              w_q_pop;
    logic [EntryW-1:0] w_q_data;

    gblit_front #(
        .LIM        (Lim),
        .SPAN_BYTES (SpanBytes),
        .IW         (Iw)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .o_valid     (w_f_valid),
        .i_ready     (w_f_ready),
        .o_entry     (w_f_entry)
    );

    gblit_queue #(
        .WIDTH (EntryW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_entry),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data)
    );

    gblit_back #(
        .SPAN_BYTES (SpanBytes),
        .IW         (Iw)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

endmodule
